/* hdl/blfc_pkg.sv */
// Shared types and constants for the backlight level fade controller.
// No dependencies; blfc_datapath, blfc_ctrl and the top level refer to it by scoped names.
package blfc_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ON       = 3'd1,
    OP_OFF      = 3'd2,
    OP_TOGGLE   = 3'd3,
    OP_SET      = 3'd4,
    OP_FADE_OFF = 3'd5,
    OP_FADE_ON  = 3'd6,
    OP_PREDIM   = 3'd7
  } opcode_t;

  // Fade sequencing phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_SETTLE   = 2'd1,
    PH_RAMP_ON  = 2'd2,
    PH_RAMP_OFF = 2'd3
  } phase_t;

  // Controller -> datapath strobes
  typedef struct packed {
    logic load;       // latch the accepted word
    logic div_start;  // launch the divider
    logic commit;     // apply the update, result becomes visible
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic need_div;   // latched command needs a quotient
    logic div_done;   // quotient ready
  } dp_status_t;

  // Register map
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_LEVEL_CEILING = 3'd0;

endpackage

/* hdl/blfc_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by blfc_datapath.
module blfc_divider #(
  parameter int unsigned DW = 20,
  parameter int unsigned VW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] dvs;

  logic [VW:0]   shifted;
  logic [VW:0]   trial;
  logic          ge;

  assign shifted  = {rem, quo[DW-1]};
  assign ge       = shifted >= {1'b0, dvs};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? trial[VW-1:0] : shifted[VW-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

endmodule

/* hdl/blfc_datapath.sv */
// Level, flag and fade state registers plus the next-state logic.
// Depends on blfc_pkg and blfc_divider.
module blfc_datapath #(
  parameter int unsigned LEVEL_BITS      = 12,
  parameter int unsigned FULL_FADE_TICKS = 125,
  parameter int unsigned MIN_FADE_TICKS  = 20,
  parameter int unsigned SETTLE_TICKS    = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  blfc_pkg::ctrl_cmd_t         cmd,
  output blfc_pkg::dp_status_t        status,
  input  logic [2:0]                  opcode,
  input  logic signed [LEVEL_BITS:0]  requested_level,
  input  logic [LEVEL_BITS-1:0]       level_ceiling,
  output logic [LEVEL_BITS-1:0]       live_level,
  output logic                        is_on,
  output logic [LEVEL_BITS-1:0]       user_level,
  output logic                        fading
);

  localparam int unsigned LB = LEVEL_BITS;
  localparam int unsigned DW = LEVEL_BITS + 8;
  localparam logic [7:0] FULL8   = 8'(FULL_FADE_TICKS);
  localparam logic [7:0] MIN8    = 8'(MIN_FADE_TICKS);
  localparam logic [7:0] SETTLE8 = 8'(SETTLE_TICKS);

  // latched word
  blfc_pkg::opcode_t     op_q;
  logic signed [LB:0]    req_q;

  // block state
  logic [LB-1:0]         drive, drive_next;
  logic                  on_flag, on_flag_next;
  logic [LB-1:0]         rem_lvl, rem_lvl_next;
  blfc_pkg::phase_t      phase, phase_next;
  logic [LB-1:0]         ramp_start, ramp_start_next;
  logic [LB-1:0]         ramp_target, ramp_target_next;
  logic [7:0]            ramp_len, ramp_len_next;
  logic [7:0]            elapsed, elapsed_next;

  // derived values
  logic [LB-1:0]         m_eff;
  logic [LB-1:0]         fade_lvl;
  logic [LB-1:0]         on_lvl;
  logic [7:0]            elapsed_inc;
  logic [7:0]            len_eff;
  logic                  ramping;
  logic                  ramp_more;
  logic                  fade_cmd;
  logic                  diff_neg;
  logic [LB-1:0]         mag;
  logic [DW-1:0]         dividend;
  logic [LB-1:0]         divisor;
  logic [DW-1:0]         quo;
  logic [7:0]            fade_len;
  logic [LB-1:0]         ramp_val;
  logic [LB-1:0]         set_lvl;
  logic                  do_on;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= blfc_pkg::opcode_t'(opcode);
      req_q <= requested_level;
    end
  end

  assign m_eff       = (level_ceiling == '0) ? LB'(255) : level_ceiling;
  assign fade_lvl    = (rem_lvl == '0) ? m_eff : rem_lvl;
  assign on_lvl      = (rem_lvl == '0) ? level_ceiling : rem_lvl;
  assign elapsed_inc = elapsed + 8'd1;
  assign len_eff     = (ramp_len == 8'd0) ? 8'd1 : ramp_len;
  assign ramping     = (phase == blfc_pkg::PH_RAMP_ON) || (phase == blfc_pkg::PH_RAMP_OFF);
  assign ramp_more   = elapsed_inc < len_eff;
  assign fade_cmd    = (op_q == blfc_pkg::OP_FADE_OFF) || (op_q == blfc_pkg::OP_FADE_ON);
  assign diff_neg    = ramp_target < ramp_start;
  assign mag         = diff_neg ? (ramp_start - ramp_target) : (ramp_target - ramp_start);

  // fade length: FULL*L/M; ramp step: |to-from|*(elapsed+1)/len, sign applied after
  assign dividend = fade_cmd ? (DW'(FULL8) * DW'(fade_lvl)) : (DW'(mag) * DW'(elapsed_inc));
  assign divisor  = fade_cmd ? m_eff : LB'(len_eff);

  assign status.need_div = fade_cmd ||
                           ((op_q == blfc_pkg::OP_TICK) && ramping && ramp_more);

  blfc_divider #(
    .DW (DW),
    .VW (LB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (status.div_done),
    .quotient (quo)
  );

  assign fade_len = (quo < DW'(MIN8)) ? MIN8 :
                    ((quo > DW'(255)) ? 8'd255 : quo[7:0]);
  assign ramp_val = diff_neg ? (ramp_start - quo[LB-1:0]) : (ramp_start + quo[LB-1:0]);

  // clamp to [0, max]
  assign set_lvl = req_q[LB] ? '0 :
                   ((req_q[LB-1:0] > level_ceiling) ? level_ceiling : req_q[LB-1:0]);

  assign do_on = (op_q == blfc_pkg::OP_ON) || ((op_q == blfc_pkg::OP_TOGGLE) && !on_flag);

  always_comb begin
    drive_next       = drive;
    on_flag_next     = on_flag;
    rem_lvl_next     = rem_lvl;
    phase_next       = phase;
    ramp_start_next  = ramp_start;
    ramp_target_next = ramp_target;
    ramp_len_next    = ramp_len;
    elapsed_next     = elapsed;
    if (cmd.commit) begin
      // anything but a tick cancels a running fade
      if (op_q != blfc_pkg::OP_TICK) begin
        phase_next   = blfc_pkg::PH_IDLE;
        elapsed_next = 8'd0;
      end
      case (op_q)
        blfc_pkg::OP_TICK: begin
          if (phase == blfc_pkg::PH_SETTLE) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= SETTLE8) begin
              phase_next   = blfc_pkg::PH_RAMP_ON;
              elapsed_next = 8'd0;
              drive_next   = ramp_start;
            end
          end else if (ramping) begin
            if (!ramp_more) begin
              if (phase == blfc_pkg::PH_RAMP_OFF) begin
                drive_next   = '0;
                on_flag_next = 1'b0;
              end else begin
                drive_next = ramp_target;
              end
              phase_next   = blfc_pkg::PH_IDLE;
              elapsed_next = 8'd0;
            end else begin
              elapsed_next = elapsed_inc;
              drive_next   = ramp_val;
            end
          end
        end
        blfc_pkg::OP_ON, blfc_pkg::OP_OFF, blfc_pkg::OP_TOGGLE: begin
          if (do_on) begin
            rem_lvl_next = on_lvl;
            drive_next   = on_lvl;
            on_flag_next = 1'b1;
          end else begin
            if (drive != '0) begin
              rem_lvl_next = drive;
            end
            drive_next   = '0;
            on_flag_next = 1'b0;
          end
        end
        blfc_pkg::OP_SET: begin
          drive_next = set_lvl;
          if (set_lvl != '0) begin
            rem_lvl_next = set_lvl;
            on_flag_next = 1'b1;
          end else begin
            on_flag_next = 1'b0;
          end
        end
        blfc_pkg::OP_FADE_OFF: begin
          ramp_len_next    = fade_len;
          ramp_start_next  = fade_lvl;
          ramp_target_next = LB'(1);
          phase_next       = blfc_pkg::PH_RAMP_OFF;
          drive_next       = fade_lvl;
        end
        blfc_pkg::OP_FADE_ON: begin
          ramp_len_next    = fade_len;
          ramp_start_next  = LB'(1);
          ramp_target_next = fade_lvl;
          on_flag_next     = 1'b1;
          drive_next       = LB'(1);
          phase_next       = (SETTLE8 == 8'd0) ? blfc_pkg::PH_RAMP_ON : blfc_pkg::PH_SETTLE;
        end
        default: begin
          drive_next = LB'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive       <= '0;
      on_flag     <= 1'b0;
      rem_lvl     <= LB'(255);
      phase       <= blfc_pkg::PH_IDLE;
      ramp_start  <= '0;
      ramp_target <= '0;
      ramp_len    <= 8'd20;
      elapsed     <= 8'd0;
    end else begin
      drive       <= drive_next;
      on_flag     <= on_flag_next;
      rem_lvl     <= rem_lvl_next;
      phase       <= phase_next;
      ramp_start  <= ramp_start_next;
      ramp_target <= ramp_target_next;
      ramp_len    <= ramp_len_next;
      elapsed     <= elapsed_next;
    end
  end

  // state only moves on commit, so it doubles as the result register
  assign live_level = drive;
  assign is_on      = on_flag;
  assign user_level = rem_lvl;
  assign fading     = phase != blfc_pkg::PH_IDLE;

endmodule

/* hdl/blfc_ctrl.sv */
// Sequencer: accept, optional divide, commit when the result slot is free.
// Depends on blfc_pkg.
module blfc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  blfc_pkg::dp_status_t  status,
  output blfc_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_COMMIT
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = state == ST_IDLE;

  assign cmd.load      = s_tvalid && s_tready;
  assign cmd.div_start = (state == ST_PREP) && status.need_div;
  assign cmd.commit    = (state == ST_COMMIT) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          state <= status.need_div ? ST_DIV : ST_COMMIT;
        end
        ST_DIV: begin
          if (status.div_done) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/backlight_level_fade_controller.sv */
// Backlight level fade controller: top level, APB register and stream ports.
// Depends on blfc_pkg, blfc_ctrl and blfc_datapath (with blfc_divider).
// Flow: a word is accepted in idle, its operands are formed in prep, fades and mid-ramp
//   ticks then run a LEVEL_BITS+8 step divide, and the result commits once the slot is free.
// One word at a time: a new word is accepted only after the last one has committed.
// Reset: rst synchronous active high; level 0, off, user level 255, max 255, no fade.
module backlight_level_fade_controller #(
  parameter int unsigned LEVEL_BITS      = 12,
  parameter int unsigned FULL_FADE_TICKS = 125,
  parameter int unsigned MIN_FADE_TICKS  = 20,
  parameter int unsigned SETTLE_TICKS    = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((LEVEL_BITS+8)/8)*8-1:0]    s_tdata,   // requested_level (signed), zero pad
  input  logic [2:0]                         s_tuser,   // opcode
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [((2*LEVEL_BITS+9)/8)*8-1:0]  m_tdata,   // live_level, is_on, user_level,
                                                        // fading, zero pad
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [blfc_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned LB    = LEVEL_BITS;
  localparam int unsigned OUT_W = ((2*LEVEL_BITS+9)/8)*8;

  logic [LB-1:0]         level_ceiling;
  logic                  reg_sel;

  blfc_pkg::ctrl_cmd_t   cmd;
  blfc_pkg::dp_status_t  status;

  logic [LB-1:0]         live_level;
  logic                  is_on;
  logic [LB-1:0]         user_level;
  logic                  fading;

  // --- config register ---
  // Writes land on the access phase; nothing else guards them, so software
  // only writes while no word is in flight.
  assign pready  = 1'b1;
  assign reg_sel = paddr == blfc_pkg::ADDR_LEVEL_CEILING;
  assign prdata  = reg_sel ? 32'(level_ceiling) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_ceiling <= LB'(255);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      level_ceiling <= pwdata[LB-1:0];
    end
  end

  // --- sequencer ---
  // Idle -> prep (operands formed from the latched word) -> divide if the
  // command needs a quotient -> commit once the result slot is free.
  blfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // --- datapath ---
  // State registers change only on commit, so they hold the pending result
  // steady while the next word is accepted and worked on.
  blfc_datapath #(
    .LEVEL_BITS      (LEVEL_BITS),
    .FULL_FADE_TICKS (FULL_FADE_TICKS),
    .MIN_FADE_TICKS  (MIN_FADE_TICKS),
    .SETTLE_TICKS    (SETTLE_TICKS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .opcode          (s_tuser),
    .requested_level (s_tdata[LB:0]),
    .level_ceiling   (level_ceiling),
    .live_level      (live_level),
    .is_on           (is_on),
    .user_level      (user_level),
    .fading          (fading)
  );

  // result word, live_level in the low bits, fading on top
  assign m_tdata = OUT_W'({fading, user_level, is_on, live_level});

endmodule

/* hdl/blfc_checker.sv */
// Port-level checks for the backlight level fade controller, with bind.
// Depends on backlight_level_fade_controller ports only.
module blfc_checker #(
  parameter int unsigned LEVEL_BITS = 12
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [((2*LEVEL_BITS+9)/8)*8-1:0] m_tdata
);

  localparam int unsigned FADE_BIT = 2*LEVEL_BITS + 1;

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped before it was taken");

  // result payload holds while stalled
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // one word in flight: no back-to-back accepts
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while one is in flight");

  // a fade or settle never drives the light fully dark
  a_fade_lit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[FADE_BIT] |-> m_tdata[LEVEL_BITS-1:0] != '0)
    else $error("live level zero while fading");

endmodule

bind backlight_level_fade_controller blfc_checker #(
  .LEVEL_BITS (LEVEL_BITS)
) u_blfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/testbench.sv */
// Self-checking bench for backlight_level_fade_controller: drives command words
// into the stream port, programs the level ceiling over APB and checks every result.
// Depends on blfc_pkg and the RTL under hdl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Mirrors the RTL defaults
  localparam int unsigned FULL_FADE_TICKS = 125;
  localparam int unsigned MIN_FADE_TICKS  = 20;
  localparam int unsigned SETTLE_TICKS    = 20;

  // Leave slack before config writes and at the end
  localparam int DRAIN_SLACK  = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 600_000;

  // One result word as seen on m_tdata
  typedef struct packed {
    logic [11:0] live_level;
    logic        is_on;
    logic [11:0] user_level;
    logic        fading;
  } light_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // requested_level[12:0] (signed), zero pad
  logic [2:0]  s_tuser = '0;  // opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // live_level, is_on, user_level, fading, zero pad
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [blfc_pkg::APB_ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  backlight_level_fade_controller DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Controller mirror: same state as the block, advanced once per accepted word
  // ---------------------------------------------------------------------------
  logic [11:0]      max_cfg   = 12'd255;
  logic [11:0]      level_now = '0;
  logic             lit       = 1'b0;
  logic [11:0]      user_lvl  = 12'd255;
  blfc_pkg::phase_t phase     = blfc_pkg::PH_IDLE;
  logic [11:0]      ramp_from = '0;
  logic [11:0]      ramp_to   = '0;
  logic [7:0]       ramp_len  = 8'd20;
  logic [7:0]       ticks     = '0;

  light_word_t expected_lights[$];
  int          mismatch_count = 0;
  bit          steady = 1'b0;         // no idling on either side while set
  bit          stall_request = 1'b0;  // asks the receiver for a long hold-off

  // Fade level: user level, or the effective max when the user level is zero
  function automatic logic [11:0] fade_level();
    logic [11:0] m;
    m = (max_cfg != 0) ? max_cfg : 12'd255;
    return (user_lvl != 0) ? user_lvl : m;
  endfunction

  // 125 * L / M, floored at 20 and capped at 255 (L above about 2*M saturates)
  function automatic logic [7:0] fade_ticks(input logic [11:0] lvl);
    int unsigned m, d;
    m = (max_cfg != 0) ? max_cfg : 255;
    d = (FULL_FADE_TICKS * lvl) / m;
    if (d < MIN_FADE_TICKS) d = MIN_FADE_TICKS;
    if (d > 255) d = 255;
    return d[7:0];
  endfunction

  function automatic void switch_on();
    // user level zero reloads from max as is, which may itself be zero
    if (user_lvl == 0) user_lvl = max_cfg;
    level_now = user_lvl;
    lit = 1'b1;
  endfunction

  function automatic void switch_off();
    if (level_now != 0) user_lvl = level_now;
    level_now = '0;
    lit = 1'b0;
  endfunction

  function automatic void advance_fade();
    int len, diff, v;
    if (phase == blfc_pkg::PH_SETTLE) begin
      ticks = ticks + 8'd1;
      if (ticks >= SETTLE_TICKS) begin
        phase = blfc_pkg::PH_RAMP_ON;
        ticks = '0;
        level_now = ramp_from;
      end
    end else if (phase == blfc_pkg::PH_RAMP_ON || phase == blfc_pkg::PH_RAMP_OFF) begin
      len = (ramp_len != 0) ? int'(ramp_len) : 1;
      ticks = ticks + 8'd1;
      if (int'(ticks) >= len) begin
        // last step lands exactly: off goes to 0 and drops the on flag
        if (phase == blfc_pkg::PH_RAMP_OFF) begin
          level_now = '0;
          lit = 1'b0;
        end else begin
          level_now = ramp_to;
        end
        phase = blfc_pkg::PH_IDLE;
        ticks = '0;
      end else begin
        // signed interpolation, division truncates toward zero
        diff = int'(ramp_to) - int'(ramp_from);
        v = int'(ramp_from) + (diff * int'(ticks)) / len;
        level_now = v[11:0];
      end
    end
  endfunction

  function automatic light_word_t step_controller(input blfc_pkg::opcode_t op,
                                                  input logic signed [12:0] req);
    int          lv;
    logic [11:0] lvl;
    light_word_t res;
    // any command other than a tick cancels a running fade, level stays
    if (op != blfc_pkg::OP_TICK) begin
      phase = blfc_pkg::PH_IDLE;
      ticks = '0;
    end
    case (op)
      blfc_pkg::OP_TICK:   advance_fade();
      blfc_pkg::OP_ON:     switch_on();
      blfc_pkg::OP_OFF:    switch_off();
      blfc_pkg::OP_TOGGLE: begin
        if (lit) switch_off();
        else switch_on();
      end
      blfc_pkg::OP_SET: begin
        lv = req;
        if (lv < 0) lv = 0;
        if (lv > int'(max_cfg)) lv = int'(max_cfg);
        level_now = lv[11:0];
        // set 0 turns off but keeps the remembered level
        if (level_now != 0) begin
          user_lvl = level_now;
          lit = 1'b1;
        end else begin
          lit = 1'b0;
        end
      end
      blfc_pkg::OP_FADE_OFF: begin
        lvl = fade_level();
        ramp_len = fade_ticks(lvl);
        ramp_from = lvl;
        ramp_to = 12'd1;
        phase = blfc_pkg::PH_RAMP_OFF;
        ticks = '0;
        level_now = lvl;
      end
      blfc_pkg::OP_FADE_ON: begin
        lvl = fade_level();
        ramp_len = fade_ticks(lvl);
        ramp_from = 12'd1;
        ramp_to = lvl;
        lit = 1'b1;
        level_now = 12'd1;
        ticks = '0;
        phase = (SETTLE_TICKS == 0) ? blfc_pkg::PH_RAMP_ON : blfc_pkg::PH_SETTLE;
      end
      default: level_now = 12'd1;  // predim
    endcase
    res.live_level = level_now;
    res.is_on      = lit;
    res.user_level = user_lvl;
    res.fading     = (phase != blfc_pkg::PH_IDLE);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one word, holds it until accepted, then logs the expected result.
  // tvalid is left high so back-to-back words need no extra edge.
  task automatic send_word(input blfc_pkg::opcode_t op, input logic [12:0] lvl);
    if (!steady) begin
      while ($urandom_range(99) < 31) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, lvl};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    expected_lights.push_back(step_controller(op, lvl));
  endtask

  // Sender stops and waits out every pending result plus divider slack
  task automatic wait_until_idle();
    s_tvalid <= 1'b0;
    while (expected_lights.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // APB write: setup then access; pready is tied high but still honored
  task automatic write_level_ceiling(input logic [11:0] value);
    wait_until_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= blfc_pkg::ADDR_LEVEL_CEILING;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    max_cfg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result check
  // ---------------------------------------------------------------------------
  initial begin
    light_word_t got, want;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.live_level = m_tdata[11:0];
        got.is_on      = m_tdata[12];
        got.user_level = m_tdata[24:13];
        got.fading     = m_tdata[25];
        if (expected_lights.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          mismatch_count++;
        end else begin
          want = expected_lights.pop_front();
          if (got.live_level !== want.live_level) begin
            $error("live_level: expected %0d, got %0d", want.live_level, got.live_level);
            mismatch_count++;
          end
          if (got.is_on !== want.is_on) begin
            $error("is_on: expected %0d, got %0d", want.is_on, got.is_on);
            mismatch_count++;
          end
          if (got.user_level !== want.user_level) begin
            $error("user_level: expected %0d, got %0d", want.user_level, got.user_level);
            mismatch_count++;
          end
          if (got.fading !== want.fading) begin
            $error("fading: expected %0d, got %0d", want.fading, got.fading);
            mismatch_count++;
          end
        end
      end
      // long hold-off is counted here so the sender keeps pushing meanwhile
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 31);
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // on/off/toggle/predim, set at the field extremes, ticks while idle
  task automatic test_plain_commands();
    send_word(blfc_pkg::OP_TICK, 13'h1FFF);
    send_word(blfc_pkg::OP_ON, '0);
    send_word(blfc_pkg::OP_OFF, 13'h1FFF);
    send_word(blfc_pkg::OP_TOGGLE, '0);     // acts as on
    send_word(blfc_pkg::OP_TOGGLE, '0);     // acts as off
    send_word(blfc_pkg::OP_SET, 13'h1000);  // most negative, clamps to 0
    send_word(blfc_pkg::OP_SET, 13'h1FFF);  // -1
    send_word(blfc_pkg::OP_SET, 13'h0FFF);  // most positive, clamps to max
    send_word(blfc_pkg::OP_SET, 13'd1);
    send_word(blfc_pkg::OP_SET, 13'd256);
    send_word(blfc_pkg::OP_SET, 13'd0);     // off, remembered level kept
    send_word(blfc_pkg::OP_PREDIM, 13'h0AAA);
    send_word(blfc_pkg::OP_ON, 13'h1555);
    send_word(blfc_pkg::OP_TICK, '0);
  endtask

  // fade starts, settle ticks, cancel by a command mid-fade
  task automatic test_fade_cancel();
    send_word(blfc_pkg::OP_FADE_ON, '0);
    repeat (3) send_word(blfc_pkg::OP_TICK, 13'($urandom));
    send_word(blfc_pkg::OP_SET, 13'd200);   // cancels the settle phase
    send_word(blfc_pkg::OP_FADE_OFF, '0);
    repeat (2) send_word(blfc_pkg::OP_TICK, 13'($urandom));
    send_word(blfc_pkg::OP_ON, '0);         // cancels the ramp
    send_word(blfc_pkg::OP_TICK, '0);
  endtask

  // Random traffic: mostly fades followed by tick runs, with noise commands
  task automatic run_random_traffic(input int n_words);
    int sent, pick, n_ticks;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_word((pick < 15) ? blfc_pkg::OP_FADE_ON : blfc_pkg::OP_FADE_OFF, 13'($urandom));
        if ($urandom_range(19) == 0) n_ticks = $urandom_range(200, 290);
        else if ($urandom_range(3) == 0) n_ticks = $urandom_range(0, 25);
        else n_ticks = $urandom_range(25, 150);
        repeat (n_ticks) send_word(blfc_pkg::OP_TICK, 13'($urandom));
        sent += n_ticks + 1;
      end else if (pick < 50) begin
        // levels around the valid range to vary fade lengths and clamping
        send_word(blfc_pkg::OP_SET,
                  13'(int'($urandom_range(0, int'(max_cfg) + 40)) - 20));
        sent++;
      end else if (pick < 70) begin
        n_ticks = $urandom_range(1, 10);
        repeat (n_ticks) send_word(blfc_pkg::OP_TICK, 13'($urandom));
        sent += n_ticks;
      end else begin
        send_word(blfc_pkg::opcode_t'($urandom_range(7)), 13'($urandom));
        sent++;
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    steady = 1'b1;
    stall_request = 1'b1;
    send_word(blfc_pkg::OP_FADE_ON, '0);
    repeat (12) send_word(blfc_pkg::OP_TICK, 13'($urandom));
    steady = 1'b0;
  endtask

  // Sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    run_random_traffic(20);
    wait_until_idle();
    run_random_traffic(20);
  endtask

  // Remembered level above max: fade length saturates at 255
  task automatic test_length_saturation();
    write_level_ceiling(12'd4095);
    send_word(blfc_pkg::OP_SET, 13'd4095);
    write_level_ceiling(12'd100);
    send_word(blfc_pkg::OP_FADE_OFF, '0);
    repeat (258) send_word(blfc_pkg::OP_TICK, 13'($urandom));
    send_word(blfc_pkg::OP_FADE_ON, '0);
    repeat (280) send_word(blfc_pkg::OP_TICK, 13'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_commands();
    test_fade_cancel();
    run_random_traffic(200);
    test_backpressure();
    test_drain_pause();

    write_level_ceiling(12'd0);    // fades fall back to 255
    run_random_traffic(100);
    write_level_ceiling(12'd4095);
    steady = 1'b1;                 // long stretch with no idling
    run_random_traffic(150);
    steady = 1'b0;
    write_level_ceiling(12'd1);
    run_random_traffic(60);
    write_level_ceiling(12'($urandom_range(2, 4094)));
    run_random_traffic(100);
    test_length_saturation();

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* backlight_level_fade_controller.f */
hdl/blfc_pkg.sv
hdl/blfc_divider.sv
hdl/blfc_datapath.sv
hdl/blfc_ctrl.sv
hdl/backlight_level_fade_controller.sv
hdl/blfc_checker.sv
tb/testbench.sv
